// ===== src/rglap_pkg.sv =====
// shared types and constants for the rssi gate crossing lap detector
package rglap_pkg;

   localparam int MASK_SLOTS = 8;

   typedef enum logic [2:0] {
      CSR_ENTRY    = 3'd0,
      CSR_EXIT     = 3'd1,
      CSR_COOLDOWN = 3'd2,
      CSR_ALPHA    = 3'd3,
      CSR_MASK     = 3'd4
   } csr_index_type;

   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   localparam logic [7:0]  ENTRY_RESET    = 8'hC4;
   localparam logic [7:0]  EXIT_RESET     = 8'hBA;
   localparam logic [15:0] COOLDOWN_RESET = 16'd3000;
   localparam logic [8:0]  ALPHA_RESET    = 9'd77;
   localparam logic [7:0]  MASK_RESET     = 8'h00;
   localparam logic [8:0]  ALPHA_ONE      = 9'd256;

   typedef struct packed {
      logic [7:0]  entry;
      logic [7:0]  exit_lvl;
      logic [15:0] cooldown;
      logic [8:0]  alpha;
      logic [7:0]  mask;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] now;
   } walk_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  pilot;
      logic [31:0] ms;
   } report_type;

   typedef struct packed {
      logic       we;
      logic [2:0] slot;
      logic [7:0] rssi;
   } packet_type;

endpackage

// ===== src/rglap_cell.sv =====
// one pilot slot: ema smoothing, crossing tracking and lap decision
module rglap_cell #(
   parameter int SLOT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rglap_pkg::cfg_type    cfg,
   input  rglap_pkg::packet_type pkt,
   input  logic                 hold,
   input  rglap_pkg::walk_type   walk_in,
   output rglap_pkg::walk_type   walk_out,
   output rglap_pkg::report_type report,
   output logic                 busy
);

   localparam bit IN_MASK = (SLOT < rglap_pkg::MASK_SLOTS);
   localparam logic [2:0] SLOT_ID = 3'(SLOT);

   logic        [7:0]  raw_ff, raw_in;
   logic signed [15:0] avg_ff, avg_in;
   logic               cross_ff, cross_in;
   logic        [7:0]  peak_ff, peak_in;
   logic        [31:0] peak_t_ff, peak_t_in;
   logic        [31:0] prev_t_ff, prev_t_in;
   logic        [31:0] last_t_ff, last_t_in;
   logic               prev_ok_ff, prev_ok_in;
   logic               tok_ff, tok_in;
   logic               phase_ff, phase_in;
   logic        [31:0] now_ff, now_in;

   logic               active;
   logic signed [17:0] diff;
   logic signed [9:0]  alpha_s;
   logic signed [27:0] prod;
   logic signed [27:0] acc;
   logic        [7:0]  whole;
   logic               above;
   logic               below;
   logic               new_peak;
   logic        [31:0] pk_t;
   logic               lap_ok;
   logic               go;

   assign active  = IN_MASK ? cfg.mask[SLOT_ID] : 1'b0;
   assign alpha_s = $signed({1'b0, cfg.alpha});
   assign diff    = 18'($signed({raw_ff, 8'h00})) - 18'(avg_ff);
   assign prod    = 28'(diff) * 28'(alpha_s);
   assign acc     = $signed({{4{avg_ff[15]}}, avg_ff, 8'h00}) + prod + 28'sd128;

   assign whole    = avg_ff[15:8] + 8'(avg_ff[15] && (avg_ff[7:0] != 8'h00));
   assign above    = avg_ff > $signed({cfg.entry, 8'h00});
   assign below    = avg_ff < $signed({cfg.exit_lvl, 8'h00});
   assign new_peak = $signed(whole) > $signed(peak_ff);
   assign pk_t     = new_peak ? now_ff : peak_t_ff;
   assign lap_ok   = (now_ff - last_t_ff) >= {16'h0000, cfg.cooldown};
   assign go       = !hold;

   always_comb begin
      report.valid = tok_ff && phase_ff && active && cross_ff && below && lap_ok;
      report.pilot = SLOT_ID;
      report.ms    = prev_ok_ff ? (pk_t - prev_t_ff) : 32'h0;
   end

   assign walk_out.valid = tok_ff && phase_ff && go;
   assign walk_out.now   = now_ff;
   assign busy           = tok_ff;

   always_comb begin
      raw_in     = raw_ff;
      avg_in     = avg_ff;
      cross_in   = cross_ff;
      peak_in    = peak_ff;
      peak_t_in  = peak_t_ff;
      prev_t_in  = prev_t_ff;
      last_t_in  = last_t_ff;
      prev_ok_in = prev_ok_ff;
      tok_in     = tok_ff;
      phase_in   = phase_ff;
      now_in     = now_ff;

      // packet write
      if (pkt.we && pkt.slot == SLOT_ID && active) begin
         raw_in = pkt.rssi;
      end

      if (walk_in.valid) begin
         tok_in   = 1'b1;
         phase_in = 1'b0;
         now_in   = walk_in.now;
      end else if (tok_ff && !phase_ff) begin
         phase_in = 1'b1;
         if (active) begin
            avg_in = acc[23:8];
         end
      end else if (tok_ff && phase_ff && go) begin
         tok_in   = 1'b0;
         phase_in = 1'b0;
         if (active) begin
            if (!cross_ff) begin
               if (above) begin
                  cross_in  = 1'b1;
                  peak_in   = whole;
                  peak_t_in = now_ff;
               end
            end else begin
               if (new_peak) begin
                  peak_in   = whole;
                  peak_t_in = now_ff;
               end
               if (below) begin
                  cross_in = 1'b0;
                  if (lap_ok) begin
                     prev_t_in  = pk_t;
                     prev_ok_in = 1'b1;
                     last_t_in  = now_ff;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff     <= 8'h00;
         avg_ff     <= 16'sh0000;
         cross_ff   <= 1'b0;
         peak_ff    <= 8'h00;
         peak_t_ff  <= 32'h0;
         prev_t_ff  <= 32'h0;
         last_t_ff  <= 32'h0;
         prev_ok_ff <= 1'b0;
         tok_ff     <= 1'b0;
         phase_ff   <= 1'b0;
         now_ff     <= 32'h0;
      end else begin
         raw_ff     <= raw_in;
         avg_ff     <= avg_in;
         cross_ff   <= cross_in;
         peak_ff    <= peak_in;
         peak_t_ff  <= peak_t_in;
         prev_t_ff  <= prev_t_in;
         last_t_ff  <= last_t_in;
         prev_ok_ff <= prev_ok_in;
         tok_ff     <= tok_in;
         phase_ff   <= phase_in;
         now_ff     <= now_in;
      end
   end

endmodule

// ===== src/rssi_gate_crossing_lap_detector.sv =====
// top level: request intake, slot cell chain, lap result queue and config registers
//
//  channel  direction  handshake            carries
//  req_     in         req_valid/req_stall  action, pilot_slot, raw_rssi, time_ms
//  rsp_     out        rsp_valid/rsp_stall  lap_pilot, lap_ms, last_lap
//  csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
//  a packet request sets its slot's raw rssi if the slot is active; a tick walks a
//  token down the cell chain, each cell smoothing its average and then deciding on
//  a lap; a flush state emits the final lap; either can wait on a stalled output
//  reset is synchronous and clears all slot state and config to defaults
//  req_stall is high for the whole tick walk and flush; csr writes are always ready
module rssi_gate_crossing_lap_detector #(
   parameter int PILOT_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [2:0]  req_pilot_slot,
   input  logic signed [7:0] req_raw_rssi,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_lap_pilot,
   output logic [31:0] rsp_lap_ms,
   output logic        rsp_last_lap,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   rglap_pkg::cfg_type   cfg_ff;
   rglap_pkg::cfg_type   cfg_eff;
   rglap_pkg::packet_type pkt;
   rglap_pkg::walk_type  link [PILOT_SLOTS+1];
   rglap_pkg::report_type rep [PILOT_SLOTS];
   rglap_pkg::report_type rep_sel;
   logic [PILOT_SLOTS-1:0] tok_vec;

   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_pilot_ff, out_pilot_in;
   logic [31:0] out_ms_ff, out_ms_in;
   logic        out_last_ff, out_last_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [2:0]  pend_pilot_ff, pend_pilot_in;
   logic [31:0] pend_ms_ff, pend_ms_in;

   logic req_take;
   logic out_free;
   logic hold;
   logic walk_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid     = out_valid_ff;
   assign rsp_lap_pilot = out_pilot_ff;
   assign rsp_lap_ms    = out_ms_ff;
   assign rsp_last_lap  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry    <= rglap_pkg::ENTRY_RESET;
         cfg_ff.exit_lvl <= rglap_pkg::EXIT_RESET;
         cfg_ff.cooldown <= rglap_pkg::COOLDOWN_RESET;
         cfg_ff.alpha    <= rglap_pkg::ALPHA_RESET;
         cfg_ff.mask     <= rglap_pkg::MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rglap_pkg::CSR_ENTRY:    cfg_ff.entry    <= csr_data[7:0];
            rglap_pkg::CSR_EXIT:     cfg_ff.exit_lvl <= csr_data[7:0];
            rglap_pkg::CSR_COOLDOWN: cfg_ff.cooldown <= csr_data;
            rglap_pkg::CSR_ALPHA:    cfg_ff.alpha    <= csr_data[8:0];
            rglap_pkg::CSR_MASK:     cfg_ff.mask     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // alpha saturates at one
   always_comb begin
      cfg_eff = cfg_ff;
      if (cfg_ff.alpha > rglap_pkg::ALPHA_ONE) begin
         cfg_eff.alpha = rglap_pkg::ALPHA_ONE;
      end
   end

   assign pkt.we   = req_take && (req_action == rglap_pkg::ACT_PACKET);
   assign pkt.slot = req_pilot_slot;
   assign pkt.rssi = req_raw_rssi;

   assign link[0].valid = req_take && (req_action == rglap_pkg::ACT_TICK);
   assign link[0].now   = req_time_ms;

   generate
      for (genvar g = 0; g < PILOT_SLOTS; g++) begin : g_cell
         rglap_cell #(
            .SLOT (g)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .cfg      (cfg_eff),
            .pkt      (pkt),
            .hold     (hold),
            .walk_in  (link[g]),
            .walk_out (link[g+1]),
            .report   (rep[g]),
            .busy     (tok_vec[g])
         );
      end
   endgenerate

   // at most one cell holds the token
   always_comb begin
      rep_sel = '0;
      for (int i = 0; i < PILOT_SLOTS; i++) begin
         if (rep[i].valid) begin
            rep_sel = rep[i];
         end
      end
   end

   assign hold     = rep_sel.valid && pend_valid_ff && out_valid_ff && rsp_stall;
   assign walk_end = link[PILOT_SLOTS].valid;

   always_comb begin
      state_in      = state_ff;
      out_valid_in  = out_valid_ff;
      out_pilot_in  = out_pilot_ff;
      out_ms_in     = out_ms_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_pilot_in = pend_pilot_ff;
      pend_ms_in    = pend_ms_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (link[0].valid) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (rep_sel.valid && !hold) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_pilot_in = pend_pilot_ff;
                  out_ms_in    = pend_ms_ff;
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_pilot_in = rep_sel.pilot;
               pend_ms_in    = rep_sel.ms;
            end
            if (walk_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_pilot_in  = pend_pilot_ff;
               out_ms_in     = pend_ms_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      out_pilot_ff  <= out_pilot_in;
      out_ms_ff     <= out_ms_in;
      out_last_ff   <= out_last_in;
      pend_pilot_ff <= pend_pilot_in;
      pend_ms_ff    <= pend_ms_in;
   end

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one cell holds the tick token");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (tok_vec == '0 && !pend_valid_ff))
      else $error("idle with a walk or pending lap in flight");

   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      hold |-> (pend_valid_ff && out_valid_ff && state_ff == ST_WALK))
      else $error("walk held without both result slots full");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && pend_valid_ff && out_free) |=> (rsp_valid && rsp_last_lap))
      else $error("final lap of a tick not marked last");

endmodule

// ===== sim/tb_rssi_gate_crossing_lap_detector.sv =====
// self-checking testbench for the rssi gate crossing lap detector, directed and random requests
module tb_rssi_gate_crossing_lap_detector;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 42;
   localparam int LAPS_WANTED = 48;
   localparam logic [2:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic [2:0]  pilot;
      logic [31:0] ms;
      logic        is_last;
   } lap_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = rglap_pkg::ACT_PACKET;
   logic [2:0] req_pilot_slot = '0;
   logic signed [7:0] req_raw_rssi = '0;
   logic [31:0] req_time_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_lap_pilot;
   logic [31:0] rsp_lap_ms;
   logic rsp_last_lap;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   // predictor copy of the registers and per-slot state
   int entry_dbm = int'($signed(rglap_pkg::ENTRY_RESET));
   int exit_dbm = int'($signed(rglap_pkg::EXIT_RESET));
   logic [15:0] cooldown_ms = rglap_pkg::COOLDOWN_RESET;
   logic [8:0] alpha_q08 = rglap_pkg::ALPHA_RESET;
   logic [7:0] active_mask = rglap_pkg::MASK_RESET;
   int raw_dbm [rglap_pkg::MASK_SLOTS] = '{default: 0};
   int level_q88 [rglap_pkg::MASK_SLOTS] = '{default: 0};
   bit crossing [rglap_pkg::MASK_SLOTS] = '{default: 1'b0};
   int peak_dbm [rglap_pkg::MASK_SLOTS] = '{default: 0};
   logic [31:0] peak_at [rglap_pkg::MASK_SLOTS] = '{default: 32'd0};
   logic [31:0] prev_peak_at [rglap_pkg::MASK_SLOTS] = '{default: 32'd0};
   logic [31:0] lap_at [rglap_pkg::MASK_SLOTS] = '{default: 32'd0};
   bit have_prev [rglap_pkg::MASK_SLOTS] = '{default: 1'b0};

   lap_record_type pending_laps [$];
   int laps_predicted = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit gaps_on = 1'b1;
   bit stall_on = 1'b1;
   logic [31:0] now_ms = 32'd0;

   rssi_gate_crossing_lap_detector dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_pilot_slot(req_pilot_slot),
      .req_raw_rssi(req_raw_rssi),
      .req_time_ms(req_time_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_lap_pilot(rsp_lap_pilot),
      .rsp_lap_ms(rsp_lap_ms),
      .rsp_last_lap(rsp_last_lap),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int pick_level(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int smooth(input int avg, input int raw);
      longint w;
      longint acc;
      w = (alpha_q08 > rglap_pkg::ALPHA_ONE) ? 256 : longint'(alpha_q08);
      acc = w * raw * 256 + (256 - w) * avg + 128;
      return int'(acc >>> 8);
   endfunction

   task automatic predict_laps(input logic [31:0] now);
      int avg;
      int whole;
      logic [31:0] since;
      lap_record_type lap;
      int found;
      found = 0;
      for (int s = 0; s < rglap_pkg::MASK_SLOTS; s++) begin
         if (active_mask[s]) begin
            avg = smooth(level_q88[s], raw_dbm[s]);
            level_q88[s] = avg;
            whole = avg / 256;
            if (!crossing[s]) begin
               if (avg > entry_dbm * 256) begin
                  crossing[s] = 1'b1;
                  peak_dbm[s] = whole;
                  peak_at[s] = now;
               end
            end else begin
               if (whole > peak_dbm[s]) begin
                  peak_dbm[s] = whole;
                  peak_at[s] = now;
               end
               if (avg < exit_dbm * 256) begin
                  since = now - lap_at[s];
                  if (since >= {16'd0, cooldown_ms}) begin
                     lap.pilot = 3'(s);
                     lap.ms = have_prev[s] ? peak_at[s] - prev_peak_at[s] : 32'd0;
                     lap.is_last = 1'b0;
                     prev_peak_at[s] = peak_at[s];
                     have_prev[s] = 1'b1;
                     lap_at[s] = now;
                     pending_laps.push_back(lap);
                     found++;
                  end
                  crossing[s] = 1'b0;
               end
            end
         end
      end
      if (found > 0) pending_laps[pending_laps.size() - 1].is_last = 1'b1;
      laps_predicted += found;
   endtask

   task automatic send_request(input logic act, input logic [2:0] slot,
                               input logic signed [7:0] rssi, input logic [31:0] ms);
      int gap;
      bit taken;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_pilot_slot <= slot;
      req_raw_rssi <= rssi;
      req_time_ms <= ms;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      if (act == rglap_pkg::ACT_TICK) begin
         predict_laps(ms);
      end else if (active_mask[slot]) begin
         raw_dbm[slot] = int'(rssi);
      end
   endtask

   task automatic send_packet(input int slot, input int rssi);
      send_request(rglap_pkg::ACT_PACKET, 3'(slot), 8'(rssi), $urandom);
   endtask

   task automatic tick_after(input logic [31:0] step);
      now_ms = now_ms + step;
      send_request(rglap_pkg::ACT_TICK, 3'($urandom), 8'($urandom), now_ms);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_laps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      case (idx)
         rglap_pkg::CSR_ENTRY:    entry_dbm = int'($signed(data[7:0]));
         rglap_pkg::CSR_EXIT:     exit_dbm = int'($signed(data[7:0]));
         rglap_pkg::CSR_COOLDOWN: cooldown_ms = data;
         rglap_pkg::CSR_ALPHA:    alpha_q08 = data[8:0];
         rglap_pkg::CSR_MASK:     active_mask = data[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input int entry, input int exit_lvl, input logic [15:0] cool,
                                 input logic [8:0] alpha, input logic [7:0] mask);
      quiesce();
      write_register(rglap_pkg::CSR_ENTRY, {8'($urandom), 8'(entry)});
      write_register(rglap_pkg::CSR_EXIT, {8'($urandom), 8'(exit_lvl)});
      write_register(rglap_pkg::CSR_COOLDOWN, cool);
      write_register(rglap_pkg::CSR_ALPHA, {7'($urandom), alpha});
      write_register(rglap_pkg::CSR_MASK, {8'($urandom), mask});
   endtask

   task automatic flag_mismatch(input string what, input lap_record_type want,
                                input lap_record_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("lap %s: expected pilot %0d ms %0d last %0d, got pilot %0d ms %0d last %0d",
                  what, want.pilot, want.ms, want.is_last, got.pilot, got.ms, got.is_last);
   endtask

   always @(negedge clock) begin
      lap_record_type got;
      lap_record_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pilot = rsp_lap_pilot;
         got.ms = rsp_lap_ms;
         got.is_last = rsp_last_lap;
         if (pending_laps.size() == 0) begin
            want = '0;
            flag_mismatch("with nothing pending", want, got);
         end else begin
            want = pending_laps.pop_front();
            if (got.pilot !== want.pilot || got.ms !== want.ms || got.is_last !== want.is_last)
               flag_mismatch("mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_reset_defaults();
      send_packet(0, 127);
      tick_after(32'd1000);
      quiesce();
      write_register(rglap_pkg::CSR_MASK, 16'h0001);
      tick_after(32'd1000);
      send_packet(0, -128);
      tick_after(32'd1000);
      tick_after(32'd1000);
      tick_after(32'd1000);
   endtask

   task automatic test_register_extremes();
      apply_settings(127, -128, 16'd0, 9'd0, 8'hFF);
      write_register(CSR_SPARE, 16'hFFFF);
      send_packet(7, 127);
      tick_after(32'd5);
      apply_settings(-128, 127, 16'hFFFF, 9'h1FF, 8'h80);
      send_packet(7, 127);
      tick_after(32'd70000);
      send_packet(7, -128);
      tick_after(32'd1);
   endtask

   task automatic test_simultaneous_laps();
      apply_settings(-60, 127, 16'd0, rglap_pkg::ALPHA_ONE, 8'hFF);
      send_packet(3, -20);
      tick_after(32'hFFFF_FF00 - now_ms);
      tick_after(32'h0000_0200);
   endtask

   task automatic test_cooldown();
      apply_settings(-60, -70, 16'd500, rglap_pkg::ALPHA_ONE, 8'h04);
      send_packet(2, -10);
      tick_after(32'd600);
      send_packet(2, -100);
      tick_after(32'd600);
      send_packet(2, -10);
      tick_after(32'd100);
      send_packet(2, -100);
      tick_after(32'd100);
   endtask

   task automatic test_random_traffic();
      int phase;
      int entry;
      int exit_lvl;
      int kind;
      int slot;
      int level;
      logic [15:0] cool;
      logic [8:0] alpha;
      logic [7:0] mask;
      phase = 0;
      while ((phase < 6 || laps_predicted < LAPS_WANTED) && phase < 7) begin
         entry = pick_level(-110, -20);
         exit_lvl = pick_level(-128, entry);
         if ($urandom_range(0, 4) == 0) begin
            entry = pick_level(-128, 127);
            exit_lvl = pick_level(-128, 127);
         end
         case ($urandom_range(0, 5))
            0: cool = 16'hFFFF;
            1: cool = 16'($urandom);
            default: cool = 16'($urandom_range(0, 800));
         endcase
         case ($urandom_range(0, 7))
            0: alpha = 9'd0;
            1, 2: alpha = 9'($urandom_range(257, 511));
            3, 4: alpha = rglap_pkg::ALPHA_ONE;
            default: alpha = 9'($urandom_range(1, 255));
         endcase
         mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         apply_settings(entry, exit_lvl, cool, alpha, mask);
         gaps_on = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         if (phase == 2) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
         repeat (ITEMS_PER_PHASE) begin
            kind = $urandom_range(0, 99);
            slot = $urandom_range(0, 7);
            if (kind < 35) begin
               while (!mask[slot]) slot = $urandom_range(0, 7);
               if ($urandom_range(0, 1) == 0)
                  level = (entry >= 127) ? 127 : pick_level(entry + 1, 127);
               else
                  level = (exit_lvl <= -128) ? -128 : pick_level(-128, exit_lvl - 1);
               send_packet(slot, level);
            end else if (kind < 45) begin
               send_packet(slot, int'($signed(8'($urandom))));
            end else if (kind < 97) begin
               tick_after($urandom_range(0, 300));
            end else begin
               tick_after($urandom);
            end
         end
         phase++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_simultaneous_laps();
      test_cooldown();
      test_random_traffic();
      quiesce();
      if (mismatch_count == 0 && pending_laps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
